/* rtl/tswt_pkg.sv */
// ============================================================================
// TCP send window tracker package
// Shared types, constants and codes for the send window tracker block.
// ============================================================================
package tswt_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [SEQ_W-1:0] WINDOW_RESET = 32'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_SEQUENCE  = 2'd0,
        REG_RECEIVE_WINDOW    = 2'd1,
        REG_CONGESTION_WINDOW = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_EMPTY       = 3'd1,
        STATUS_WINDOW_FULL = 3'd2,
        STATUS_ACK_BEYOND  = 3'd3,
        STATUS_QUEUE_FULL  = 3'd4
    } status_t;

    typedef enum logic {
        ACTION_SEND = 1'b0,
        ACTION_ACK  = 1'b1
    } action_t;

    typedef struct packed {
        logic             action;
        logic [LEN_W-1:0] request_length;
        logic [SEQ_W-1:0] ack_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [SEQ_W-1:0] segment_sequence;
        logic [LEN_W-1:0] granted_length;
        logic [SEQ_W-1:0] acked_bytes;
        logic [SEQ_W-1:0] in_flight;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_APPLY,
        ST_RETIRE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic decide;
        logic apply;
        logic pop;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        logic is_ack;
        logic commit;
        logic retire_hit;
    } dp_status_t;

endpackage

/* rtl/tswt_datapath.sv */
// ============================================================================
// TCP send window tracker datapath
// Sequence pointers, window registers, segment end queue and the arithmetic
// for grants, acknowledgements and the reported result.
// ============================================================================
module tswt_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tswt_pkg::dp_cmd_t                  cmd,
    output tswt_pkg::dp_status_t               stat,
    input  tswt_pkg::in_item_t                 request,
    input  logic                               cfg_we,
    input  logic [tswt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tswt_pkg::SEQ_W-1:0]         cfg_data,
    output tswt_pkg::out_item_t                result
);

    logic [tswt_pkg::SEQ_W-1:0]  oldest_reg;
    logic [tswt_pkg::SEQ_W-1:0]  next_seq_reg;
    logic [tswt_pkg::SEQ_W-1:0]  rwin_reg;
    logic [tswt_pkg::SEQ_W-1:0]  cwin_reg;
    logic [tswt_pkg::QPTR_W-1:0] head_reg;
    logic [tswt_pkg::QPTR_W-1:0] head_next;
    logic [tswt_pkg::QPTR_W-1:0] tail_reg;
    logic [tswt_pkg::QCNT_W-1:0] count_reg;
    logic [tswt_pkg::SEQ_W-1:0]  ends_mem [tswt_pkg::QUEUE_DEPTH];
    logic [tswt_pkg::SEQ_W-1:0]  head_end_reg;

    tswt_pkg::in_item_t          item_reg;
    logic [tswt_pkg::SEQ_W-1:0]  win_reg;
    logic [tswt_pkg::SEQ_W-1:0]  flight_reg;
    logic [tswt_pkg::SEQ_W-1:0]  cap_reg;
    logic                        ack_eq_reg;
    logic                        ack_gt_reg;
    tswt_pkg::status_t           status_reg;
    logic                        commit_reg;
    logic [tswt_pkg::LEN_W-1:0]  granted_reg;
    logic [tswt_pkg::SEQ_W-1:0]  seg_seq_reg;
    logic [tswt_pkg::SEQ_W-1:0]  acked_reg;
    tswt_pkg::out_item_t         result_reg;

    logic [tswt_pkg::SEQ_W-1:0]  len_ext;
    logic [tswt_pkg::SEQ_W-1:0]  new_end;
    logic                        queue_full;
    logic                        send_ok;
    logic                        ack_ok;
    logic                        send_commit;
    logic                        ack_commit;

    function automatic logic [tswt_pkg::QPTR_W-1:0] wrap_inc(
        input logic [tswt_pkg::QPTR_W-1:0] ptr
    );
        logic [tswt_pkg::QPTR_W-1:0] res;
        if (ptr == tswt_pkg::QPTR_W'(tswt_pkg::QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign len_ext     = {{(tswt_pkg::SEQ_W - tswt_pkg::LEN_W){1'b0}}, item_reg.request_length};
    assign new_end     = next_seq_reg + {{(tswt_pkg::SEQ_W - tswt_pkg::LEN_W){1'b0}}, granted_reg};
    assign queue_full  = (count_reg == tswt_pkg::QCNT_W'(tswt_pkg::QUEUE_DEPTH));
    assign send_ok     = (item_reg.request_length != '0) && (cap_reg != '0) && !queue_full;
    assign ack_ok      = !ack_eq_reg && !ack_gt_reg;
    assign send_commit = cmd.apply && commit_reg && (item_reg.action == tswt_pkg::ACTION_SEND);
    assign ack_commit  = cmd.apply && commit_reg && (item_reg.action == tswt_pkg::ACTION_ACK);
    assign head_next   = cmd.pop ? wrap_inc(head_reg) : head_reg;

    assign stat.is_ack     = (item_reg.action == tswt_pkg::ACTION_ACK);
    assign stat.commit     = commit_reg;
    assign stat.retire_hit = (count_reg != '0) && (head_end_reg <= item_reg.ack_number);
    assign result          = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg   <= '0;
            next_seq_reg <= '0;
            rwin_reg     <= tswt_pkg::WINDOW_RESET;
            cwin_reg     <= tswt_pkg::WINDOW_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tswt_pkg::REG_INITIAL_SEQUENCE:
                    begin
                        oldest_reg   <= cfg_data;
                        next_seq_reg <= cfg_data;
                    end
                    tswt_pkg::REG_RECEIVE_WINDOW:    rwin_reg <= cfg_data;
                    tswt_pkg::REG_CONGESTION_WINDOW: cwin_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (send_commit)
            begin
                next_seq_reg <= new_end;
                tail_reg     <= wrap_inc(tail_reg);
                count_reg    <= count_reg + 1'b1;
            end
            if (ack_commit)
            begin
                oldest_reg <= item_reg.ack_number;
            end
            if (cmd.pop)
            begin
                head_reg  <= wrap_inc(head_reg);
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (send_commit)
        begin
            ends_mem[tail_reg] <= new_end;
        end
        head_end_reg <= ends_mem[head_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg   <= request;
            win_reg    <= (rwin_reg < cwin_reg) ? rwin_reg : cwin_reg;
            flight_reg <= next_seq_reg - oldest_reg;
        end
        if (cmd.eval)
        begin
            cap_reg    <= (flight_reg >= win_reg) ? '0 : (win_reg - flight_reg);
            ack_eq_reg <= (item_reg.ack_number == oldest_reg);
            ack_gt_reg <= (item_reg.ack_number > next_seq_reg);
        end
        if (cmd.decide)
        begin
            status_reg  <= tswt_pkg::STATUS_OK;
            commit_reg  <= 1'b0;
            granted_reg <= '0;
            seg_seq_reg <= '0;
            acked_reg   <= '0;
            if (item_reg.action == tswt_pkg::ACTION_SEND)
            begin
                if (item_reg.request_length == '0)
                begin
                    status_reg <= tswt_pkg::STATUS_EMPTY;
                end
                else if (cap_reg == '0)
                begin
                    status_reg <= tswt_pkg::STATUS_WINDOW_FULL;
                end
                else if (queue_full)
                begin
                    status_reg <= tswt_pkg::STATUS_QUEUE_FULL;
                end
                if (send_ok)
                begin
                    commit_reg  <= 1'b1;
                    granted_reg <= (len_ext < cap_reg) ? item_reg.request_length
                                                       : cap_reg[tswt_pkg::LEN_W-1:0];
                    seg_seq_reg <= next_seq_reg;
                end
            end
            else
            begin
                if (!ack_eq_reg && ack_gt_reg)
                begin
                    status_reg <= tswt_pkg::STATUS_ACK_BEYOND;
                end
                if (ack_ok)
                begin
                    commit_reg <= 1'b1;
                    acked_reg  <= item_reg.ack_number - oldest_reg;
                end
            end
        end
        if (cmd.report)
        begin
            result_reg.status           <= status_reg;
            result_reg.segment_sequence <= seg_seq_reg;
            result_reg.granted_length   <= granted_reg;
            result_reg.acked_bytes      <= acked_reg;
            result_reg.in_flight        <= next_seq_reg - oldest_reg;
        end
    end

endmodule

/* rtl/tswt_ctrl.sv */
// ============================================================================
// TCP send window tracker controller
// Sequences each item through evaluation, decision, update, queue retirement
// and reporting, and drives the busy and done signals.
// ============================================================================
module tswt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    output tswt_pkg::dp_cmd_t     cmd,
    input  tswt_pkg::dp_status_t  stat
);

    tswt_pkg::state_t state_reg;
    tswt_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tswt_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            tswt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tswt_pkg::ST_EVAL;
                end
            end
            tswt_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = tswt_pkg::ST_DECIDE;
            end
            tswt_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = tswt_pkg::ST_APPLY;
            end
            tswt_pkg::ST_APPLY:
            begin
                cmd.apply = 1'b1;
                if (stat.is_ack && stat.commit)
                begin
                    state_next = tswt_pkg::ST_RETIRE;
                end
                else
                begin
                    state_next = tswt_pkg::ST_REPORT;
                end
            end
            tswt_pkg::ST_RETIRE:
            begin
                if (stat.retire_hit)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    state_next = tswt_pkg::ST_REPORT;
                end
            end
            tswt_pkg::ST_REPORT:
            begin
                cmd.report = 1'b1;
                done_next  = 1'b1;
                state_next = tswt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tswt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tswt_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

/* rtl/tcp_send_window_tracker_core.sv */
// ============================================================================
// TCP send window tracker
// Tracks a TCP sender's sliding window: grants send requests against the
// available window, queues segment ends and retires them on acknowledgement.
// ============================================================================
// An item is taken when start is high while busy is low. A send, and an
// acknowledgement that is a duplicate or lies beyond sent data, passes through
// the evaluate, decide, apply and report states before the done strobe; an
// accepted acknowledgement also stays in the retire state while it retires
// queued segments, as the segment end queue is examined one entry per cycle.
// The result is shown for exactly one cycle with done high and cannot be held
// off by the receiver. Busy is already low in that cycle, so the next item may
// be started alongside it. Configuration writes are taken while busy is low
// and no item is being started in the same cycle.
module tcp_send_window_tracker_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tswt_pkg::in_item_t                 request,
    output logic                               done,
    output tswt_pkg::out_item_t                result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tswt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tswt_pkg::SEQ_W-1:0]         cfg_data
);

    tswt_pkg::dp_cmd_t    cmd;
    tswt_pkg::dp_status_t stat;
    logic                 cfg_we;

    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    tswt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    tswt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

/* tb/tswt_window_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// TCP send window tracker checker
// Watches the request, result and register channels of the tracker. It keeps
// its own copy of the sliding window state, works out the result of every
// accepted item and compares each result, field by field, with the oldest
// outstanding prediction. The predicted window state is exported so that the
// stimulus can aim acknowledgements at meaningful sequence numbers.
// ============================================================================
module tswt_window_checker
    import tswt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  in_item_t             request,
    input  logic                 done,
    input  out_item_t            result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEQ_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding,
    output logic [SEQ_W-1:0]     track_next,
    output logic [SEQ_W-1:0]     track_oldest,
    output logic [SEQ_W-1:0]     track_head_end,
    output int                   track_queued
);

    logic [SEQ_W-1:0] rcv_wnd;
    logic [SEQ_W-1:0] cong_wnd;
    logic [SEQ_W-1:0] snd_una;
    logic [SEQ_W-1:0] snd_nxt;
    logic [SEQ_W-1:0] seg_end [QUEUE_DEPTH];
    int               seg_head;
    int               seg_tail;
    int               seg_count;
    int               mismatches;
    out_item_t        pending_results [$];

    function automatic out_item_t advance_window(in_item_t req);
        out_item_t        r;
        logic [SEQ_W-1:0] win;
        logic [SEQ_W-1:0] flight;
        logic [SEQ_W-1:0] cap;
        logic [SEQ_W-1:0] granted;
        logic [SEQ_W-1:0] prev;
        r = '0;
        r.status = STATUS_OK;
        if (req.action == ACTION_SEND)
        begin
            win = (rcv_wnd < cong_wnd) ? rcv_wnd : cong_wnd;
            flight = snd_nxt - snd_una;
            cap = (flight >= win) ? '0 : win - flight;
            if (req.request_length == '0)
            begin
                r.status = STATUS_EMPTY;
            end
            else if (cap == '0)
            begin
                r.status = STATUS_WINDOW_FULL;
            end
            else if (seg_count >= QUEUE_DEPTH)
            begin
                r.status = STATUS_QUEUE_FULL;
            end
            else
            begin
                granted = ({16'd0, req.request_length} < cap) ? {16'd0, req.request_length} : cap;
                r.segment_sequence = snd_nxt;
                r.granted_length = granted[LEN_W-1:0];
                snd_nxt = snd_nxt + granted;
                seg_end[seg_tail] = snd_nxt;
                seg_tail = (seg_tail + 1) % QUEUE_DEPTH;
                seg_count++;
            end
        end
        else
        begin
            prev = snd_una;
            if (req.ack_number == prev)
            begin
                r.acked_bytes = '0;
            end
            else if (req.ack_number > snd_nxt)
            begin
                r.status = STATUS_ACK_BEYOND;
            end
            else
            begin
                snd_una = req.ack_number;
                while (seg_count > 0 && seg_end[seg_head] <= req.ack_number)
                begin
                    seg_head = (seg_head + 1) % QUEUE_DEPTH;
                    seg_count--;
                end
                r.acked_bytes = req.ack_number - prev;
            end
        end
        r.in_flight = snd_nxt - snd_una;
        return r;
    endfunction

    task automatic check_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            rcv_wnd = WINDOW_RESET;
            cong_wnd = WINDOW_RESET;
            snd_una = '0;
            snd_nxt = '0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                seg_end[i] = '0;
            end
            seg_head = 0;
            seg_tail = 0;
            seg_count = 0;
            mismatches = 0;
            pending_results.delete();
            fail_count <= 0;
            outstanding <= 0;
            track_next <= '0;
            track_oldest <= '0;
            track_head_end <= '0;
            track_queued <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INITIAL_SEQUENCE:
                    begin
                        snd_una = cfg_data;
                        snd_nxt = cfg_data;
                    end
                    REG_RECEIVE_WINDOW:    rcv_wnd = cfg_data;
                    REG_CONGESTION_WINDOW: cong_wnd = cfg_data;
                    default:               ;
                endcase
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result seen with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("status", {29'd0, want.status}, {29'd0, result.status});
                    check_field("segment_sequence", want.segment_sequence,
                                result.segment_sequence);
                    check_field("granted_length", {16'd0, want.granted_length},
                                {16'd0, result.granted_length});
                    check_field("acked_bytes", want.acked_bytes, result.acked_bytes);
                    check_field("in_flight", want.in_flight, result.in_flight);
                end
            end
            if (start && !busy)
            begin
                pending_results.insert(pending_results.size(), advance_window(request));
            end
            fail_count <= mismatches;
            outstanding <= pending_results.size();
            track_next <= snd_nxt;
            track_oldest <= snd_una;
            track_head_end <= (seg_count > 0) ? seg_end[seg_head] : snd_nxt;
            track_queued <= seg_count;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// TCP send window tracker testbench
// Drives send and acknowledgement items into the tracker through a short
// directed sequence and then six randomised phases, each with its own
// register setting and one of three sender idling patterns. The checker beside
// the block predicts and compares every result; this module gives the verdict.
// ============================================================================
module tb_top;
    import tswt_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_item_t             request = '0;
    logic                 done;
    out_item_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEQ_W-1:0]     cfg_data = '0;

    int                   fail_count;
    int                   outstanding;
    logic [SEQ_W-1:0]     track_next;
    logic [SEQ_W-1:0]     track_oldest;
    logic [SEQ_W-1:0]     track_head_end;
    int                   track_queued;

    int                   idle_cycles = 0;
    int                   items_sent = 0;
    int                   results_seen = 0;
    int                   settings_applied = 0;

    always #10 clk = ~clk;

    tcp_send_window_tracker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tswt_window_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .done           (done),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .track_next     (track_next),
        .track_oldest   (track_oldest),
        .track_head_end (track_head_end),
        .track_queued   (track_queued)
    );

    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen <= results_seen + 1;
        end
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no activity for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic in_item_t make_item(action_t act, logic [LEN_W-1:0] len,
                                           logic [SEQ_W-1:0] ack);
        in_item_t it;
        it.action = act;
        it.request_length = len;
        it.ack_number = ack;
        return it;
    endfunction

    function automatic int idle_gap(int pct);
        int gap;
        gap = 0;
        while (gap < 150 && $urandom_range(99) < pct)
        begin
            gap++;
        end
        return gap;
    endfunction

    function automatic in_item_t random_item();
        in_item_t         it;
        int               pick;
        logic [SEQ_W-1:0] span;
        it.request_length = LEN_W'($urandom);
        it.ack_number = $urandom;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            it.action = ACTION_SEND;
            pick = $urandom_range(99);
            if (pick < 70)
                it.request_length = LEN_W'($urandom_range(2000, 1));
            else if (pick < 80)
                it.request_length = '0;
            else if (pick < 90)
                it.request_length = '1;
        end
        else
        begin
            it.action = ACTION_ACK;
            span = track_next - track_oldest;
            pick = $urandom_range(99);
            if (pick < 30)
                it.ack_number = track_next;
            else if (pick < 50)
                it.ack_number = track_head_end;
            else if (pick < 70)
                it.ack_number = track_oldest + ((span == '1) ? $urandom : $urandom % (span + 1));
            else if (pick < 80)
                it.ack_number = track_oldest;
            else if (pick < 90)
                it.ack_number = track_next + $urandom_range(5000, 1);
            else if (pick < 95)
                it.ack_number = track_oldest - $urandom_range(500, 1);
        end
        return it;
    endfunction

    task automatic drive_item(in_item_t it, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= it;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (outstanding != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_setting(logic [SEQ_W-1:0] iss, logic [SEQ_W-1:0] rwnd,
                                 logic [SEQ_W-1:0] cwnd);
        cfg_index_t       idx [3];
        logic [SEQ_W-1:0] val [3];
        idx[0] = REG_INITIAL_SEQUENCE;
        idx[1] = REG_RECEIVE_WINDOW;
        idx[2] = REG_CONGESTION_WINDOW;
        val[0] = iss;
        val[1] = rwnd;
        val[2] = cwnd;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        int               phase_items [6];
        int               pct;
        logic [SEQ_W-1:0] iss;
        logic [SEQ_W-1:0] rwnd;
        logic [SEQ_W-1:0] cwnd;
        phase_items = '{250, 250, 100, 250, 250, 250};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset window of 65535 bytes at sequence zero.
        drive_item(make_item(ACTION_SEND, 16'd0, 32'hFFFF_FFFF), 0);
        drive_item(make_item(ACTION_SEND, 16'hFFFF, 32'd0), 0);
        drive_item(make_item(ACTION_SEND, 16'd1, 32'd0), 0);
        drive_item(make_item(ACTION_ACK, 16'hFFFF, 32'd0), 0);
        drive_item(make_item(ACTION_ACK, 16'd0, 32'h0001_0000), 0);
        drive_item(make_item(ACTION_ACK, 16'd0, 32'd100), 0);
        drive_item(make_item(ACTION_ACK, 16'd0, 32'd50), 0);
        drive_item(make_item(ACTION_ACK, 16'd0, 32'd65535), 0);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
        begin
            drive_item(make_item(ACTION_SEND, 16'd1, 32'd0), 0);
        end
        drive_item(make_item(ACTION_ACK, 16'd0, 32'hFFFF_FFFF), 0);
        drive_item(make_item(ACTION_ACK, 16'd0, 32'd65535 + QUEUE_DEPTH), 0);
        start <= 1'b0;

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    iss = 32'hFFFF_FF00;
                    rwnd = 32'd5000;
                    cwnd = 32'hFFFF_FFFF;
                end
                1:
                begin
                    iss = $urandom;
                    rwnd = 32'hFFFF_FFFF;
                    cwnd = 32'hFFFF_FFFF;
                end
                2:
                begin
                    iss = 32'd0;
                    rwnd = 32'd1500;
                    cwnd = 32'd0;
                end
                3:
                begin
                    iss = $urandom;
                    rwnd = $urandom_range(200000, 1);
                    cwnd = $urandom_range(200000, 1);
                end
                4:
                begin
                    iss = 32'd0;
                    rwnd = 32'd65535;
                    cwnd = 32'd1;
                end
                default:
                begin
                    iss = 32'hFFFF_FFFF;
                    rwnd = $urandom;
                    cwnd = 32'hFFFF_FFFF;
                end
            endcase
            pct = (p < 2) ? 11 : ((p < 4) ? 86 : 0);
            wait_idle();
            apply_setting(iss, rwnd, cwnd);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                drive_item(random_item(), idle_gap(pct));
            end
            start <= 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d send and acknowledgement items under %0d register settings,",
                 items_sent, settings_applied);
        $display("with %0d results compared against the predicted window state.",
                 results_seen);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
